// ----- src/bresenham_line_to_bitplanes_assert.svh -----
// assertion macros shared by the checker
`ifndef BRESENHAM_LINE_TO_BITPLANES_ASSERT_SVH
`define BRESENHAM_LINE_TO_BITPLANES_ASSERT_SVH

// implication checked on every clock, quiet in reset
`define BLB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define BLB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- src/blb_pkg.sv -----
package blb_pkg;

    localparam int PANEL_COLUMNS = 152;
    localparam int PANEL_ROWS = 296;

    localparam logic [1:0] OP_DRAW = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    localparam logic [1:0] INK_WHITE = 2'd0;
    localparam logic [1:0] INK_BLACK = 2'd1;
    localparam logic [1:0] INK_RED = 2'd2;

    localparam logic [1:0] REG_CANVAS_WIDTH = 2'd0;
    localparam logic [1:0] REG_CANVAS_HEIGHT = 2'd1;
    localparam logic [1:0] REG_RED_PLANE_ON = 2'd2;

    localparam logic [8:0] CANVAS_WIDTH_RESET = 9'd296;
    localparam logic [7:0] CANVAS_HEIGHT_RESET = 8'd152;

    localparam logic [7:0] MASK_MSB = 8'h80;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic clr_start;
        logic clr_step;
        logic rd_issue;
        logic px_read;
        logic px_write;
        logic bres_step;
        logic rd_capture;
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic clr_last;
        logic line_last;
    } dp_stat_t;

endpackage

// ----- src/blb_if.sv -----
interface blb_item_if;
    logic valid;
    logic ready;
    logic [1:0] op;
    logic [8:0] start_x;
    logic [8:0] start_y;
    logic [8:0] end_x;
    logic [8:0] end_y;
    logic [1:0] ink;
    logic [7:0] fill_byte;
    logic [12:0] read_addr;
    modport source (output valid, op, start_x, start_y, end_x, end_y, ink, fill_byte,
        read_addr, input ready);
    modport sink (input valid, op, start_x, start_y, end_x, end_y, ink, fill_byte,
        read_addr, output ready);
endinterface

interface blb_result_if;
    logic valid;
    logic ready;
    logic status;
    logic [7:0] bw_byte;
    logic [7:0] red_byte;
    modport source (output valid, status, bw_byte, red_byte, input ready);
    modport sink (input valid, status, bw_byte, red_byte, output ready);
endinterface

interface blb_cfg_if;
    logic valid;
    logic ready;
    logic [1:0] index;
    logic [8:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- src/bresenham_line_to_bitplanes.sv -----
// channel  | dir | contents
// item_in  | in  | op, endpoints, ink, fill byte, read address
// result   | out | status, bw byte, red byte
// cfg      | in  | register index, write data
//
// a draw reads, waits for and writes back the byte of each pixel in turn (S_PX_RD, S_PX_WAIT, S_PX_WR)
// a clear writes the fill byte to all PANEL_ROWS * ceil(PANEL_COLUMNS/8) bytes, one byte a cycle
// (5624 bytes by default)
// a read issues its address, waits and captures the bytes; one item is in work at a time
// the result sits in an output register, so the next item is taken while it waits
// reset restores the register defaults; plane contents are undefined until the first clear
module bresenham_line_to_bitplanes #(
    parameter int PANEL_COLUMNS = blb_pkg::PANEL_COLUMNS,
    parameter int PANEL_ROWS = blb_pkg::PANEL_ROWS
) (
    input logic          clk,
    input logic          rst_n,
    blb_item_if.sink     item_in,
    blb_result_if.source result,
    blb_cfg_if.sink      cfg
);
    logic [8:0] canvas_width_reg;
    logic [7:0] canvas_height_reg;
    logic red_plane_on_reg;
    logic res_valid_reg, res_load, res_status;
    logic [7:0] res_bw, res_red;
    logic status_reg;
    logic [7:0] bw_reg, red_reg;
    blb_pkg::dp_cmd_t cmd;
    blb_pkg::dp_stat_t stat;

    // configuration registers
    assign cfg.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            canvas_width_reg <= blb_pkg::CANVAS_WIDTH_RESET;
            canvas_height_reg <= blb_pkg::CANVAS_HEIGHT_RESET;
            red_plane_on_reg <= 1'b1;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                blb_pkg::REG_CANVAS_WIDTH: canvas_width_reg <= cfg.data;
                blb_pkg::REG_CANVAS_HEIGHT: canvas_height_reg <= cfg.data[7:0];
                blb_pkg::REG_RED_PLANE_ON: red_plane_on_reg <= cfg.data[0];
                default: ;
            endcase
        end
    end

    blb_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(item_in.valid), .in_op(item_in.op),
        .in_ready(item_in.ready), .res_load(res_load),
        .res_busy(res_valid_reg && !result.ready), .cmd(cmd), .stat(stat));

    blb_dp #(.PANEL_COLUMNS(PANEL_COLUMNS), .PANEL_ROWS(PANEL_ROWS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .in_op(item_in.op), .in_start_x(item_in.start_x), .in_start_y(item_in.start_y),
        .in_end_x(item_in.end_x), .in_end_y(item_in.end_y), .in_ink(item_in.ink),
        .in_fill_byte(item_in.fill_byte), .in_read_addr(item_in.read_addr),
        .canvas_width(canvas_width_reg), .canvas_height(canvas_height_reg),
        .red_plane_on(red_plane_on_reg), .res_status(res_status),
        .res_bw(res_bw), .res_red(res_red));

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            status_reg <= res_status;
            bw_reg <= res_bw;
            red_reg <= res_red;
        end
    end

    assign result.valid = res_valid_reg;
    assign result.status = status_reg;
    assign result.bw_byte = bw_reg;
    assign result.red_byte = red_reg;
endmodule

// ----- src/blb_ram.sv -----
module blb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- src/blb_ctrl.sv -----
module blb_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [1:0]         in_op,
    output logic               in_ready,
    output logic               res_load,
    input  logic               res_busy,
    output blb_pkg::dp_cmd_t   cmd,
    input  blb_pkg::dp_stat_t  stat
);
    typedef enum logic [2:0] {
        S_IDLE, S_CLEAR, S_RD_WAIT, S_RD_CAP, S_PX_RD, S_PX_WAIT, S_PX_WR, S_DONE
    } state_t;

    state_t state_reg, state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        res_load = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (in_op == blb_pkg::OP_DRAW)
                    begin
                        state_next = S_PX_RD;
                    end
                    else if (in_op == blb_pkg::OP_CLEAR)
                    begin
                        cmd.clr_start = 1'b1;
                        state_next = S_CLEAR;
                    end
                    else if (in_op == blb_pkg::OP_READ)
                    begin
                        cmd.rd_issue = 1'b1;
                        state_next = S_RD_WAIT;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_RD_WAIT:
            begin
                state_next = S_RD_CAP;
            end
            S_RD_CAP:
            begin
                cmd.rd_capture = 1'b1;
                state_next = S_DONE;
            end
            S_PX_RD:
            begin
                cmd.px_read = 1'b1;
                state_next = S_PX_WAIT;
            end
            S_PX_WAIT:
            begin
                state_next = S_PX_WR;
            end
            S_PX_WR:
            begin
                cmd.px_write = 1'b1;
                if (stat.line_last)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.bres_step = 1'b1;
                    state_next = S_PX_RD;
                end
            end
            S_DONE:
            begin
                if (!res_busy)
                begin
                    res_load = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end
endmodule

// ----- src/blb_dp.sv -----
module blb_dp #(
    parameter int PANEL_COLUMNS = blb_pkg::PANEL_COLUMNS,
    parameter int PANEL_ROWS = blb_pkg::PANEL_ROWS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  blb_pkg::dp_cmd_t   cmd,
    output blb_pkg::dp_stat_t  stat,
    input  logic [1:0]         in_op,
    input  logic [8:0]         in_start_x,
    input  logic [8:0]         in_start_y,
    input  logic [8:0]         in_end_x,
    input  logic [8:0]         in_end_y,
    input  logic [1:0]         in_ink,
    input  logic [7:0]         in_fill_byte,
    input  logic [12:0]        in_read_addr,
    input  logic [8:0]         canvas_width,
    input  logic [7:0]         canvas_height,
    input  logic               red_plane_on,
    output logic               res_status,
    output logic [7:0]         res_bw,
    output logic [7:0]         res_red
);
    localparam int ROW_BYTES = (PANEL_COLUMNS + 7) / 8;
    localparam int PLANE_BYTES = ROW_BYTES * PANEL_ROWS;
    localparam int AW = $clog2(PLANE_BYTES);

    logic signed [10:0] x_reg, y_reg, x1_reg, y1_reg;
    logic signed [10:0] dx_reg, dy_reg, err_reg;
    logic sx_reg, sy_reg;
    logic [1:0] ink_reg, op_reg;
    logic [7:0] fill_reg;
    logic skip_reg, px_ok_reg;
    logic [AW-1:0] addr_reg, clr_addr_reg;
    logic [7:0] mask_reg;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic mem_we_bw, mem_we_red;
    logic [7:0] wdata_bw, wdata_red, rdata_bw, rdata_red;
    logic rd_in_range_reg;
    logic px_ok;
    logic [10:0] col_c;
    logic [22:0] addr_wide;
    logic signed [11:0] e2;

    // canvas and panel bound test on the current pixel
    assign px_ok = (x_reg >= 0) && (y_reg >= 0)
        && (x_reg < $signed({2'b00, canvas_width}))
        && (y_reg < $signed({3'b000, canvas_height}))
        && (x_reg < 12'(PANEL_ROWS)) && (y_reg < 12'(PANEL_COLUMNS));
    assign col_c = 11'(PANEL_COLUMNS - 1) - 11'(y_reg);
    assign addr_wide = 23'(col_c >> 3) + 23'(x_reg) * 23'(ROW_BYTES);
    assign e2 = {err_reg, 1'b0};

    assign stat.clr_last = (clr_addr_reg == AW'(PLANE_BYTES - 1));
    assign stat.line_last = (x_reg == x1_reg) && (y_reg == y1_reg);

    // line stepping and pixel address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_reg <= 1'b0;
            op_reg <= blb_pkg::OP_DRAW;
        end
        else if (cmd.load)
        begin
            op_reg <= in_op;
            skip_reg <= 1'b0;
        end
        else if (cmd.px_read && !px_ok)
        begin
            skip_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg <= 11'(in_start_x);
            y_reg <= 11'(in_start_y);
            x1_reg <= 11'(in_end_x);
            y1_reg <= 11'(in_end_y);
            dx_reg <= (in_end_x > in_start_x) ? 11'(in_end_x - in_start_x)
                                              : 11'(in_start_x - in_end_x);
            dy_reg <= (in_end_y > in_start_y) ? 11'(in_end_y - in_start_y)
                                              : 11'(in_start_y - in_end_y);
            err_reg <= ((in_end_x > in_start_x) ? 11'(in_end_x - in_start_x)
                                                : 11'(in_start_x - in_end_x))
                     - ((in_end_y > in_start_y) ? 11'(in_end_y - in_start_y)
                                                : 11'(in_start_y - in_end_y));
            sx_reg <= (in_start_x < in_end_x);
            sy_reg <= (in_start_y < in_end_y);
            ink_reg <= in_ink;
            fill_reg <= in_fill_byte;
        end
        else if (cmd.bres_step)
        begin
            if ((e2 > -12'(dy_reg)) && (e2 < 12'(dx_reg)))
            begin
                err_reg <= err_reg - dy_reg + dx_reg;
            end
            else if (e2 > -12'(dy_reg))
            begin
                err_reg <= err_reg - dy_reg;
            end
            else if (e2 < 12'(dx_reg))
            begin
                err_reg <= err_reg + dx_reg;
            end
            if (e2 > -12'(dy_reg))
            begin
                x_reg <= sx_reg ? x_reg + 11'sd1 : x_reg - 11'sd1;
            end
            if (e2 < 12'(dx_reg))
            begin
                y_reg <= sy_reg ? y_reg + 11'sd1 : y_reg - 11'sd1;
            end
        end
        if (cmd.px_read)
        begin
            addr_reg <= AW'(addr_wide);
            mask_reg <= blb_pkg::MASK_MSB >> col_c[2:0];
            px_ok_reg <= px_ok && (addr_wide < 23'(PLANE_BYTES));
        end
        if (cmd.rd_issue)
        begin
            addr_reg <= AW'(in_read_addr);
            rd_in_range_reg <= (32'(in_read_addr) < 32'(PLANE_BYTES));
        end
    end

    // clear sweep address
    always_ff @(posedge clk)
    begin
        if (cmd.clr_start)
        begin
            clr_addr_reg <= '0;
        end
        else if (cmd.clr_step)
        begin
            clr_addr_reg <= clr_addr_reg + AW'(1);
        end
    end

    // memory ports and read-modify-write data
    // a read item keeps its address on the port until the bytes are captured
    always_comb
    begin
        mem_raddr = cmd.rd_issue ? AW'(in_read_addr)
                  : (op_reg == blb_pkg::OP_READ) ? addr_reg : AW'(addr_wide);
        mem_waddr = cmd.clr_step ? clr_addr_reg : addr_reg;
        mem_we_bw = cmd.clr_step || (cmd.px_write && px_ok_reg);
        mem_we_red = red_plane_on && mem_we_bw;
        wdata_bw = fill_reg;
        wdata_red = fill_reg;
        if (!cmd.clr_step)
        begin
            case (ink_reg)
                blb_pkg::INK_BLACK:
                begin
                    wdata_bw = rdata_bw & ~mask_reg;
                    wdata_red = rdata_red | mask_reg;
                end
                blb_pkg::INK_RED:
                begin
                    wdata_bw = rdata_bw | mask_reg;
                    wdata_red = rdata_red & ~mask_reg;
                end
                default:
                begin
                    wdata_bw = rdata_bw | mask_reg;
                    wdata_red = rdata_red | mask_reg;
                end
            endcase
        end
    end

    blb_ram #(.WIDTH(8), .DEPTH(PLANE_BYTES)) u_bw (
        .clk(clk), .we(mem_we_bw), .waddr(mem_waddr), .wdata(wdata_bw),
        .raddr(mem_raddr), .rdata(rdata_bw));

    blb_ram #(.WIDTH(8), .DEPTH(PLANE_BYTES)) u_red (
        .clk(clk), .we(mem_we_red), .waddr(mem_waddr), .wdata(wdata_red),
        .raddr(mem_raddr), .rdata(rdata_red));

    // result assembly
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            res_bw <= '0;
            res_red <= '0;
        end
        else if (cmd.rd_capture && rd_in_range_reg)
        begin
            res_bw <= rdata_bw;
            res_red <= rdata_red;
        end
    end
    assign res_status = (op_reg == blb_pkg::OP_DRAW) && skip_reg;
endmodule

// ----- src/blb_checker.sv -----
`include "bresenham_line_to_bitplanes_assert.svh"

module blb_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic out_status,
    input logic [7:0] out_bw,
    input logic [7:0] out_red
);
    // a taken item blocks further items in the cycle after it is taken
    `BLB_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready)
    // a stalled result holds
    `BLB_ASSERT_NEXT(a_res_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    // a result with a skip flag carries no read bytes
    `BLB_ASSERT_IMP(a_status_clean, clk, rst_n, out_valid && out_status,
        out_bw == 8'd0 && out_red == 8'd0)
endmodule

bind bresenham_line_to_bitplanes blb_checker u_blb_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(item_in.valid), .in_ready(item_in.ready),
    .out_valid(result.valid), .out_ready(result.ready), .out_status(result.status),
    .out_bw(result.bw_byte), .out_red(result.red_byte));
